// ----- sv/rgbapk_pkg.sv -----
// Package: payload types, format codes and the half-float lookup table of the RGBA8 packer.
`timescale 1ns / 1ps
package rgbapk_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [15:0] byte_enable;
    logic [7:0]  bits_used;
  } packed_t;

  // Per-channel conversions used by the float, half-float and 16-bit channel formats.
  typedef struct packed {
    logic [31:0] f32;    // exact float32 of the byte
    logic [15:0] half;   // half float of byte/255
    logic [15:0] wide;   // byte * 257
    logic [15:0] snorm;  // (byte * 257) >> 1
  } chan_t;

  localparam int unsigned FmtW = 5;

  typedef enum logic [FmtW-1:0] {
    PF_RGBA32F   = 5'd0,
    PF_RGB32F    = 5'd1,
    PF_RGBA16F   = 5'd2,
    PF_RGBA16    = 5'd3,
    PF_UVWQ16    = 5'd4,
    PF_RG32F     = 5'd5,
    PF_RGBA8     = 5'd6,
    PF_UVWQ8     = 5'd7,
    PF_RG16F     = 5'd8,
    PF_RG16      = 5'd9,
    PF_UV16      = 5'd10,
    PF_R32F      = 5'd11,
    PF_XG8       = 5'd12,
    PF_RGBG8     = 5'd13,
    PF_GRGB8     = 5'd14,
    PF_BGRA8     = 5'd15,
    PF_BGRX8     = 5'd16,
    PF_RG8       = 5'd17,
    PF_UV8       = 5'd18,
    PF_HALF_R    = 5'd19,
    PF_WIDE_R    = 5'd20,
    PF_WIDE_U    = 5'd21,
    PF_BGR565    = 5'd22,
    PF_BGRA5551  = 5'd23,
    PF_BGRA4444  = 5'd24,
    PF_R8        = 5'd25,
    PF_U8        = 5'd26,
    PF_A8        = 5'd27
  } fmt_e;

  localparam logic [FmtW-1:0] FmtReset = PF_RGBA8;

  // Half float of v/255: float32 rounded to nearest, mantissa truncated to 10 bits.
  function automatic logic [15:0] half_entry(input int unsigned v);
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    logic [31:0] fbits;
    int unsigned t;
    int e;
    if (v == 0) begin
      return 16'h0000;
    end
    t = v;
    e = 0;
    for (int k = 0; k < 8; k++) begin
      if (t < 255) begin
        t = t << 1;
        e = e - 1;
      end
    end
    num = 64'(v) << (23 - e);
    q   = num / 255;
    rem = num % 255;
    if (2 * rem > 255) begin
      q = q + 64'd1;
    end
    fbits = 32'((127 + e) << 23) + 32'(q - 64'h80_0000);
    return 16'((fbits >> 13) - 32'h1_C000);
  endfunction

  function automatic logic [4095:0] build_half_lut();
    logic [4095:0] lut;
    lut = '0;
    for (int i = 0; i < 256; i++) begin
      lut[i*16 +: 16] = half_entry(i);
    end
    return lut;
  endfunction

  localparam logic [4095:0] HalfLut = build_half_lut();

endpackage

// ----- sv/rgbapk_chan.sv -----
// Channel converter: float32, half float and 16-bit widenings of one 8-bit channel.
`timescale 1ns / 1ps
module rgbapk_chan (
  input  logic [7:0]     val_i,
  output rgbapk_pkg::chan_t conv_o
);
  import rgbapk_pkg::*;

  logic [2:0]  msb;
  logic [22:0] shifted;

  // Find the leading one; the highest set bit wins.
  always_comb begin
    msb = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (val_i[k]) begin
        msb = 3'(k);
      end
    end
  end

  // Move the leading one to bit 23; it drops out of the 23-bit mantissa.
  assign shifted = 23'(val_i) << (5'd23 - 5'(msb));

  always_comb begin
    if (val_i == 8'd0) begin
      conv_o.f32 = 32'd0;
    end else begin
      conv_o.f32 = {1'b0, 8'(8'd127 + 8'(msb)), shifted};
    end
    conv_o.half  = HalfLut[{val_i, 4'b0000} +: 16];
    conv_o.wide  = {val_i, val_i};
    conv_o.snorm = {1'b0, val_i, val_i[7:1]};
  end

endmodule

// ----- sv/rgbapk_pack.sv -----
// Format packer: places converted channels into the 128-bit little-endian word.
`timescale 1ns / 1ps
module rgbapk_pack (
  input  logic [rgbapk_pkg::FmtW-1:0] fmt_i,
  input  rgbapk_pkg::pixel_t          pix_i,
  output rgbapk_pkg::packed_t         res_o
);
  import rgbapk_pkg::*;

  chan_t cr, cg, cb, ca;
  logic [127:0] data;
  logic [15:0]  en;
  logic [7:0]   bits;

  rgbapk_chan u_chan_r (.val_i(pix_i.red),   .conv_o(cr));
  rgbapk_chan u_chan_g (.val_i(pix_i.green), .conv_o(cg));
  rgbapk_chan u_chan_b (.val_i(pix_i.blue),  .conv_o(cb));
  rgbapk_chan u_chan_a (.val_i(pix_i.alpha), .conv_o(ca));

  always_comb begin
    data = '0;
    en   = '0;
    bits = 8'd0;
    unique case (fmt_e'(fmt_i))
      PF_RGBA32F: begin
        data = {ca.f32, cb.f32, cg.f32, cr.f32};
        en = 16'hFFFF; bits = 8'd128;
      end
      PF_RGB32F: begin
        data[95:0] = {cb.f32, cg.f32, cr.f32};
        en = 16'h0FFF; bits = 8'd96;
      end
      PF_RGBA16F: begin
        data[63:0] = {ca.half, cb.half, cg.half, cr.half};
        en = 16'h00FF; bits = 8'd64;
      end
      PF_RGBA16: begin
        data[63:0] = {ca.wide, cb.wide, cg.wide, cr.wide};
        en = 16'h00FF; bits = 8'd64;
      end
      PF_UVWQ16: begin
        data[63:0] = {ca.snorm, cb.snorm, cg.snorm, cr.snorm};
        en = 16'h00FF; bits = 8'd64;
      end
      PF_RG32F: begin
        data[63:0] = {cg.f32, cr.f32};
        en = 16'h00FF; bits = 8'd64;
      end
      PF_RGBA8: begin
        data[31:0] = {pix_i.alpha, pix_i.blue, pix_i.green, pix_i.red};
        en = 16'h000F; bits = 8'd32;
      end
      PF_UVWQ8: begin
        data[31:0] = {1'b0, pix_i.alpha[7:1], 1'b0, pix_i.blue[7:1],
                      1'b0, pix_i.green[7:1], 1'b0, pix_i.red[7:1]};
        en = 16'h000F; bits = 8'd32;
      end
      PF_RG16F: begin
        data[31:0] = {cg.half, cr.half};
        en = 16'h000F; bits = 8'd32;
      end
      PF_RG16: begin
        data[31:0] = {cg.wide, cr.wide};
        en = 16'h000F; bits = 8'd32;
      end
      PF_UV16: begin
        data[31:0] = {cg.snorm, cr.snorm};
        en = 16'h000F; bits = 8'd32;
      end
      PF_R32F: begin
        data[31:0] = cr.f32;
        en = 16'h000F; bits = 8'd32;
      end
      PF_XG8: begin
        data[31:24] = pix_i.green;
        en = 16'h0008; bits = 8'd32;
      end
      PF_RGBG8: begin
        data[31:0] = {pix_i.green, pix_i.blue, pix_i.green, pix_i.red};
        en = 16'h000F; bits = 8'd32;
      end
      PF_GRGB8: begin
        data[31:0] = {pix_i.blue, pix_i.green, pix_i.red, pix_i.green};
        en = 16'h000F; bits = 8'd32;
      end
      PF_BGRA8: begin
        data[31:0] = {pix_i.alpha, pix_i.red, pix_i.green, pix_i.blue};
        en = 16'h000F; bits = 8'd32;
      end
      PF_BGRX8: begin
        data[23:0] = {pix_i.red, pix_i.green, pix_i.blue};
        en = 16'h0007; bits = 8'd32;
      end
      PF_RG8: begin
        data[15:0] = {pix_i.green, pix_i.red};
        en = 16'h0003; bits = 8'd16;
      end
      PF_UV8: begin
        data[15:0] = {1'b0, pix_i.green[7:1], 1'b0, pix_i.red[7:1]};
        en = 16'h0003; bits = 8'd16;
      end
      PF_HALF_R: begin
        data[15:0] = cr.half;
        en = 16'h0003; bits = 8'd16;
      end
      PF_WIDE_R: begin
        data[15:0] = cr.wide;
        en = 16'h0003; bits = 8'd16;
      end
      PF_WIDE_U: begin
        data[15:0] = cr.snorm;
        en = 16'h0003; bits = 8'd16;
      end
      PF_BGR565: begin
        data[15:0] = {pix_i.red[7:3], pix_i.green[7:2], pix_i.blue[7:3]};
        en = 16'h0003; bits = 8'd16;
      end
      PF_BGRA5551: begin
        data[15:0] = {(pix_i.alpha != 8'd0), pix_i.red[7:3], pix_i.green[7:3],
                      pix_i.blue[7:3]};
        en = 16'h0003; bits = 8'd16;
      end
      PF_BGRA4444: begin
        data[15:0] = {pix_i.alpha[7:4], pix_i.red[7:4], pix_i.green[7:4],
                      pix_i.blue[7:4]};
        en = 16'h0003; bits = 8'd16;
      end
      PF_R8: begin
        data[7:0] = pix_i.red;
        en = 16'h0001; bits = 8'd8;
      end
      PF_U8: begin
        data[7:0] = {1'b0, pix_i.red[7:1]};
        en = 16'h0001; bits = 8'd8;
      end
      PF_A8: begin
        data[7:0] = pix_i.alpha;
        en = 16'h0001; bits = 8'd8;
      end
      default: begin
        // Unsupported code: write nothing, report zero bits.
        data = '0; en = '0; bits = 8'd0;
      end
    endcase
  end

  assign res_o.data_low    = data[63:0];
  assign res_o.data_high   = data[127:64];
  assign res_o.byte_enable = en;
  assign res_o.bits_used   = bits;

endmodule

// ----- sv/rgba8_pixel_format_packer.sv -----
// Top level: RGBA8 pixel packer with input register, format register and result register.
`timescale 1ns / 1ps
// Packs one RGBA8 pixel per beat into the format chosen by the target_format
// register (written through the cfg channel, reset value R8G8B8A8). Each
// result beat carries a little-endian 128-bit pixel split into data_low and
// data_high, a byte-enable mask of the bytes the format writes, and the pixel
// size in bits; codes 28 to 31 give an all-zero result. An accepted pixel
// is captured in the input register and passes through the conversion logic
// (leading-one detect, half-float table lookup, format select) into the
// result register once that register is free; the result beat leaves from
// the result register. Throughput is one pixel per clock; the input side
// keeps accepting while a finished result waits, and stalls only when both
// registers are full and the consumer stalls.
module rgba8_pixel_format_packer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rgbapk_pkg::pixel_t   in_data_i,
  // packed result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rgbapk_pkg::packed_t  out_data_o,
  // format register write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [rgbapk_pkg::FmtW-1:0] cfg_data_i
);
  import rgbapk_pkg::*;

  logic [FmtW-1:0] fmt_q;
  logic            in_vld_q;
  pixel_t          in_q;
  logic            out_vld_q;
  packed_t         out_q;
  packed_t         res_d;
  logic            out_free;
  logic            in_adv;
  logic            in_take;

  // The format register is always writable; write it only while no beat is
  // in flight, since a held pixel converts with the format when it advances.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtReset;
    end else if (cfg_valid_i) begin
      fmt_q <= cfg_data_i;
    end
  end

  // Result register is free when empty or its beat leaves this cycle.
  assign out_free   = !out_vld_q || !out_stall_i;
  // Advance the input stage into the result register when it is free.
  assign in_adv     = in_vld_q && out_free;
  // Stall only when both stages hold a beat and the consumer holds back.
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (in_adv) begin
        in_vld_q <= 1'b0;
      end
      if (in_adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture on acceptance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (in_adv) begin
      out_q <= res_d;
    end
  end

  // Conversion and format selection between the two registers.
  rgbapk_pack u_pack (
    .fmt_i (fmt_q),
    .pix_i (in_q),
    .res_o (res_d)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- test/rgba8_pack_checker.sv -----
// Checker: watches the pixel, result and format channels, predicts each packed result and compares.
`timescale 1ns / 1ps
module rgba8_pack_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  rgbapk_pkg::pixel_t          in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  rgbapk_pkg::packed_t         out_data_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [rgbapk_pkg::FmtW-1:0] cfg_data_i,
  output int unsigned                 in_flight_o,
  output int unsigned                 mismatches_o
);
  import rgbapk_pkg::*;

  packed_t         expected_words[$];
  logic [FmtW-1:0] format_q;

  // exact float32 of an 8-bit integer
  function automatic logic [31:0] float_of_byte(input logic [7:0] v);
    int msb;
    if (v == 8'd0) return 32'd0;
    msb = 7;
    while (!v[msb]) msb--;
    return {1'b0, 8'(127 + msb), 23'(32'(v) << (23 - msb))};
  endfunction

  // half float of v/255: round the float32 quotient to nearest, keep the top 10 mantissa bits
  function automatic logic [15:0] half_of_unit(input logic [7:0] v);
    logic [47:0] num;
    logic [47:0] quo;
    int shift;
    if (v == 8'd0) return 16'h0000;
    shift = 0;
    while ((32'(v) << shift) < 32'd255) shift++;
    num = 48'(v) << (23 + shift);
    quo = num / 48'd255;
    if (2 * (num % 48'd255) > 48'd255) quo++;
    return {1'b0, 5'(15 - shift), quo[22:13]};
  endfunction

  function automatic logic [15:0] widen(input logic [7:0] v);
    return 16'(v) * 16'd257;
  endfunction

  function automatic logic [15:0] widen_signed(input logic [7:0] v);
    return (16'(v) * 16'd257) >> 1;
  endfunction

  function automatic packed_t pack_rgba8(input logic [FmtW-1:0] fmt, input pixel_t px);
    logic [127:0] word;
    logic [15:0]  en;
    logic [7:0]   bits;
    logic [7:0]   r, g, b, a;
    packed_t      res;
    word = '0;
    en   = '0;
    bits = '0;
    r = px.red;
    g = px.green;
    b = px.blue;
    a = px.alpha;
    case (fmt)
      PF_RGBA32F: begin
        word = {float_of_byte(a), float_of_byte(b), float_of_byte(g), float_of_byte(r)};
        en = 16'hFFFF; bits = 8'd128;
      end
      PF_RGB32F: begin
        word[95:0] = {float_of_byte(b), float_of_byte(g), float_of_byte(r)};
        en = 16'h0FFF; bits = 8'd96;
      end
      PF_RGBA16F: begin
        word[63:0] = {half_of_unit(a), half_of_unit(b), half_of_unit(g), half_of_unit(r)};
        en = 16'h00FF; bits = 8'd64;
      end
      PF_RGBA16: begin
        word[63:0] = {widen(a), widen(b), widen(g), widen(r)};
        en = 16'h00FF; bits = 8'd64;
      end
      PF_UVWQ16: begin
        word[63:0] = {widen_signed(a), widen_signed(b), widen_signed(g), widen_signed(r)};
        en = 16'h00FF; bits = 8'd64;
      end
      PF_RG32F: begin
        word[63:0] = {float_of_byte(g), float_of_byte(r)};
        en = 16'h00FF; bits = 8'd64;
      end
      PF_RGBA8: begin
        word[31:0] = {a, b, g, r}; en = 16'h000F; bits = 8'd32;
      end
      PF_UVWQ8: begin
        word[31:0] = {a >> 1, b >> 1, g >> 1, r >> 1}; en = 16'h000F; bits = 8'd32;
      end
      PF_RG16F: begin
        word[31:0] = {half_of_unit(g), half_of_unit(r)}; en = 16'h000F; bits = 8'd32;
      end
      PF_RG16: begin
        word[31:0] = {widen(g), widen(r)}; en = 16'h000F; bits = 8'd32;
      end
      PF_UV16: begin
        word[31:0] = {widen_signed(g), widen_signed(r)}; en = 16'h000F; bits = 8'd32;
      end
      PF_R32F: begin
        word[31:0] = float_of_byte(r); en = 16'h000F; bits = 8'd32;
      end
      PF_XG8: begin
        word[31:24] = g; en = 16'h0008; bits = 8'd32;
      end
      PF_RGBG8: begin
        word[31:0] = {g, b, g, r}; en = 16'h000F; bits = 8'd32;
      end
      PF_GRGB8: begin
        word[31:0] = {b, g, r, g}; en = 16'h000F; bits = 8'd32;
      end
      PF_BGRA8: begin
        word[31:0] = {a, r, g, b}; en = 16'h000F; bits = 8'd32;
      end
      PF_BGRX8: begin
        word[23:0] = {r, g, b}; en = 16'h0007; bits = 8'd32;
      end
      PF_RG8: begin
        word[15:0] = {g, r}; en = 16'h0003; bits = 8'd16;
      end
      PF_UV8: begin
        word[15:0] = {g >> 1, r >> 1}; en = 16'h0003; bits = 8'd16;
      end
      PF_HALF_R: begin
        word[15:0] = half_of_unit(r); en = 16'h0003; bits = 8'd16;
      end
      PF_WIDE_R: begin
        word[15:0] = widen(r); en = 16'h0003; bits = 8'd16;
      end
      PF_WIDE_U: begin
        word[15:0] = widen_signed(r); en = 16'h0003; bits = 8'd16;
      end
      PF_BGR565: begin
        word[15:0] = {r[7:3], g[7:2], b[7:3]}; en = 16'h0003; bits = 8'd16;
      end
      PF_BGRA5551: begin
        word[15:0] = {a != 8'd0, r[7:3], g[7:3], b[7:3]}; en = 16'h0003; bits = 8'd16;
      end
      PF_BGRA4444: begin
        word[15:0] = {a[7:4], r[7:4], g[7:4], b[7:4]}; en = 16'h0003; bits = 8'd16;
      end
      PF_R8: begin
        word[7:0] = r; en = 16'h0001; bits = 8'd8;
      end
      PF_U8: begin
        word[7:0] = r >> 1; en = 16'h0001; bits = 8'd8;
      end
      PF_A8: begin
        word[7:0] = a; en = 16'h0001; bits = 8'd8;
      end
      default: ;  // unsupported code: nothing written
    endcase
    res.data_low    = word[63:0];
    res.data_high   = word[127:64];
    res.byte_enable = en;
    res.bits_used   = bits;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    packed_t want;
    if (!rst_ni) begin
      format_q = FmtReset;
      expected_words.delete();
    end else begin
      // predict with the format in force when the pixel beat lands
      if (in_valid_i && !in_stall_i) begin
        expected_words.push_back(pack_rgba8(format_q, in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("result beat with no pixel pending");
          mismatches_o++;
        end else begin
          want = expected_words.pop_front();
          if (out_data_i.data_low !== want.data_low) begin
            $error("data_low: expected %h, got %h", want.data_low, out_data_i.data_low);
            mismatches_o++;
          end
          if (out_data_i.data_high !== want.data_high) begin
            $error("data_high: expected %h, got %h", want.data_high, out_data_i.data_high);
            mismatches_o++;
          end
          if (out_data_i.byte_enable !== want.byte_enable) begin
            $error("byte_enable: expected %h, got %h", want.byte_enable,
                   out_data_i.byte_enable);
            mismatches_o++;
          end
          if (out_data_i.bits_used !== want.bits_used) begin
            $error("bits_used: expected %0d, got %0d", want.bits_used, out_data_i.bits_used);
            mismatches_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        format_q = cfg_data_i;
      end
    end
    in_flight_o = expected_words.size();
  end

endmodule

// ----- test/testbench.sv -----
// Testbench top: clock, reset, pixel and format stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module testbench;
  import rgbapk_pkg::*;

  // codes past the last defined format; the block must write nothing for them
  localparam logic [FmtW-1:0] FmtFirstUnsupported = 5'd28;
  localparam logic [FmtW-1:0] FmtLastCode         = 5'd31;

  localparam int NumPhases      = 40;  // first 32 walk every code, the rest pick at random
  localparam int PixelsPerPhase = 25;
  localparam int LongHold       = 40;  // cycles the result side holds off when asked
  localparam int SettleCycles   = 4;   // extra settling after every result is back

  // corner pixels (red, green, blue, alpha from the top byte down): zero, full scale,
  // smallest nonzero red and green, alternating bits both ways, mixed with alpha of one
  localparam pixel_t CornerPixels [6] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h01017F80,
    32'hAA55AA55, 32'h55AA55AA, 32'h80FE0001
  };

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  pixel_t          in_data;
  logic            out_valid;
  logic            out_stall;
  packed_t         out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [FmtW-1:0] cfg_data;

  int unsigned in_flight;
  int unsigned mismatches;

  // shared knobs between the pixel source and the result sink
  bit          no_idle;
  int unsigned hold_requests;
  int unsigned pixels_sent;

  rgba8_pixel_format_packer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  rgba8_pack_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_flight_o  (in_flight),
    .mismatches_o (mismatches)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hold reset low, release on a falling edge, never assert again.
  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Bound the run; a hang anywhere ends up here.
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // Draw an idle count for one beat: none during bursts, else 0..3.
  function automatic int pick_gap();
    return no_idle ? 0 : int'($urandom_range(0, 3));
  endfunction

  // Bias a quarter of the channels toward the edges of the byte range.
  function automatic logic [7:0] random_channel();
    logic [7:0] edges [6];
    edges = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red   = random_channel();
    px.green = random_channel();
    px.blue  = random_channel();
    px.alpha = random_channel();
    return px;
  endfunction

  // Offer one pixel beat. Call at a falling edge; returns at a falling edge.
  // Keep valid high across back-to-back beats: only drop it when a gap is drawn.
  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Write the format register; only called with the block drained.
  task automatic write_format(input logic [FmtW-1:0] code);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result sink: after each accepted beat, stall for a drawn number of cycles.
  // On a hold request, stall for a long stretch so the block backs up into its input.
  initial begin : result_sink
    int          stall_left;
    int unsigned holds_served;
    stall_left   = 0;
    holds_served = 0;
    out_stall    = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) stall_left = pick_gap();
      @(negedge clk);
      if (holds_served < hold_requests) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [FmtW-1:0] directed_formats [3];
    logic [FmtW-1:0] code;
    directed_formats = '{PF_RGBA32F, PF_RGBA16F, PF_BGRA5551};
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    no_idle       = 1'b0;
    hold_requests = 0;
    pixels_sent   = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);

    // Corner pixels under the reset format first, then float, half float and 5551.
    foreach (CornerPixels[i]) send_pixel(CornerPixels[i]);
    foreach (directed_formats[f]) begin
      drain();
      write_format(directed_formats[f]);
      foreach (CornerPixels[i]) send_pixel(CornerPixels[i]);
    end

    // Random phases: walk every code from 0 through the unsupported ones, then random codes.
    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      code = (phase <= int'(FmtLastCode)) ? FmtLastCode - 5'(int'(FmtLastCode) - phase)
                                          : 5'($urandom_range(0, int'(FmtLastCode)));
      write_format(code);
      no_idle = ($urandom_range(0, 3) == 0);
      // every fifth phase: back up the block behind a long output hold-off
      if (phase % 5 == 2) hold_requests++;
      for (int n = 0; n < PixelsPerPhase; n++) begin
        // now and then pause mid-phase until every result is back
        if (phase % 7 == 3 && n == PixelsPerPhase / 2) begin
          in_valid <= 1'b0;
          while (in_flight != 0) @(negedge clk);
          @(negedge clk);
        end
        send_pixel(random_pixel());
      end
    end

    drain();
    $display("Covered %0d pixels over every format code 0..%0d (unsupported from %0d),",
             pixels_sent, FmtLastCode, FmtFirstUnsupported);
    $display("with %0d long output hold-offs and drained pauses between settings.",
             hold_requests);
    if (mismatches == 0 && in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
